FILE: rtl/core/rae_pkg.sv
package rae_pkg;

	// operation codes carried in bits 31..27 of the instruction
	typedef enum logic [4:0] {
		OP_STOP = 5'd0,
		OP_ADD  = 5'd1,
		OP_SUB  = 5'd2,
		OP_MUL  = 5'd3,
		OP_DIV  = 5'd4,
		OP_AND  = 5'd5,
		OP_OR   = 5'd6,
		OP_XOR  = 5'd7,
		OP_SHL  = 5'd8,
		OP_SHR  = 5'd9,
		OP_SLT  = 5'd10,
		OP_SLE  = 5'd11,
		OP_SEQ  = 5'd12
	} opcode_t;

	// completion codes reported with each result
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_STOP    = 3'd1,
		ST_UNSUP   = 3'd2,
		ST_DIVZERO = 3'd3,
		ST_HALTED  = 3'd4
	} status_t;

	// instruction word fields
	localparam int OPC_LSB  = 27;
	localparam int SRC_LSB  = 22;
	localparam int IMM_BIT  = 21;
	localparam int OPND_LSB = 5;
	localparam int FIELD_W  = 5;
	localparam int IMM_W    = 16;
	localparam int OUT_W    = 32;

	typedef struct packed {
		logic    start;
		opcode_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic div_zero;
	} alu_rsp_t;

endpackage

FILE: rtl/core/rae_ram.sv
module rae_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/rae_alu.sv
module rae_alu
	import rae_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  alu_req_t              req,
	input  logic [DATA_WIDTH-1:0] a,
	input  logic [DATA_WIDTH-1:0] b,
	output alu_rsp_t              rsp,
	output logic [DATA_WIDTH-1:0] res
);

	localparam int W     = DATA_WIDTH;
	localparam int CNT_W = $clog2(DATA_WIDTH);
	localparam int SH_W  = $clog2(DATA_WIDTH);

	opcode_t        op_q;
	logic [W-1:0]   x_q;      // operand a, multiplicand or quotient
	logic [W-1:0]   y_q;      // operand b, multiplier or divisor
	logic [W-1:0]   acc_q;    // product or partial remainder
	logic [CNT_W-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic           dz_q;
	logic [W-1:0]   res_q;

	logic [W:0]     ax;
	logic [W:0]     ay;
	logic           sub;
	logic [W:0]     sum;
	logic [W:0]     rem_sh;
	logic [W-1:0]   single;
	logic [W-1:0]   mul_next;
	logic [W-1:0]   quo_next;
	logic [W-1:0]   rem_next;

	assign rem_sh = {acc_q, x_q[W-1]};

	// the one shared adder
	always_comb begin
		ax  = {1'b0, x_q};
		ay  = {1'b0, y_q};
		sub = 1'b0;
		case (op_q) inside
			OP_SUB, OP_SLT, OP_SEQ: begin
				sub = 1'b1;
			end
			OP_SLE: begin
				ax  = {1'b0, y_q};
				ay  = {1'b0, x_q};
				sub = 1'b1;
			end
			OP_MUL: begin
				ax = {1'b0, acc_q};
				ay = {1'b0, x_q};
			end
			OP_DIV: begin
				ax  = rem_sh;
				ay  = {1'b0, y_q};
				sub = 1'b1;
			end
			default: begin
				sub = 1'b0;
			end
		endcase
		sum = ax + (sub ? ~ay : ay) + (W+1)'(sub);
	end

	always_comb begin
		case (op_q) inside
			OP_ADD, OP_SUB: single = sum[W-1:0];
			OP_AND:         single = x_q & y_q;
			OP_OR:          single = x_q | y_q;
			OP_XOR:         single = x_q ^ y_q;
			OP_SHL:         single = (y_q < W'(DATA_WIDTH)) ? (x_q << y_q[SH_W-1:0]) : '0;
			OP_SHR:         single = (y_q < W'(DATA_WIDTH)) ? (x_q >> y_q[SH_W-1:0]) : '0;
			OP_SLT:         single = W'(sum[W]);
			OP_SLE:         single = W'(!sum[W]);
			OP_SEQ:         single = W'(sum[W-1:0] == '0);
			default:        single = '0;
		endcase
	end

	assign mul_next = y_q[0] ? sum[W-1:0] : acc_q;
	assign quo_next = {x_q[W-2:0], !sum[W]};
	assign rem_next = sum[W] ? rem_sh[W-1:0] : sum[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (req.op == OP_DIV && b == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if ((op_q != OP_MUL && op_q != OP_DIV) || cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			x_q   <= a;
			y_q   <= b;
			acc_q <= '0;
			cnt_q <= CNT_W'(DATA_WIDTH - 1);
			dz_q  <= (req.op == OP_DIV && b == '0);
			res_q <= '1;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			case (op_q)
				OP_MUL: begin
					acc_q <= mul_next;
					x_q   <= x_q << 1;
					y_q   <= y_q >> 1;
					res_q <= mul_next;
				end
				OP_DIV: begin
					acc_q <= rem_next;
					x_q   <= quo_next;
					res_q <= quo_next;
				end
				default: begin
					res_q <= single;
				end
			endcase
		end
	end

	assign rsp.done     = done_q;
	assign rsp.div_zero = dz_q;
	assign res          = res_q;

endmodule

FILE: rtl/core/register_alu_instruction_executor.sv
// stop, unsupported and post-halt transactions go straight to S_RESP; all others pass S_RDB,
// S_LOAD and S_EXEC, where a division by zero finishes without iterating and mul and div iterate
// a new transaction is accepted only once the previous result has left S_RESP, so output stalls slow the flow;
// mul and div run one shift-add or shift-subtract step per cycle on the shared adder
// operands come from one register file read port, operand a first and then operand b
// reset (arst_n low): all registers read as zero, halt flag cleared, no result pending
module register_alu_instruction_executor
	import rae_pkg::*;
#(
	parameter int REG_COUNT  = 32,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] instruction_word,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  dest_index,
	output logic [31:0] write_value,
	output logic        write_enable,
	output logic [2:0]  status
);

	localparam int W     = DATA_WIDTH;
	localparam int IDX_W = $clog2(REG_COUNT);
	localparam int EXT_W = (DATA_WIDTH > OUT_W) ? DATA_WIDTH : OUT_W;

	// sequencer states
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,  // waiting for a transaction, reading operand a
		S_RDB  = 5'b00010,  // capture a, read operand b
		S_LOAD = 5'b00100,  // capture b, kick the alu
		S_EXEC = 5'b01000,  // alu iterating
		S_RESP = 5'b10000   // result waits for the output register
	} state_t;

	state_t state_q;

	// index reduction table: a 5-bit field modulo the register count
	logic [IDX_W-1:0] idx_lut [2**FIELD_W];

	for (genvar i = 0; i < 2**FIELD_W; i++) begin : g_idx
		assign idx_lut[i] = IDX_W'(i % REG_COUNT);
	end

	// decoded fields of the incoming instruction
	logic [FIELD_W-1:0] in_opc;
	logic [IDX_W-1:0]   in_src;
	logic [IDX_W-1:0]   in_opnd;
	logic [IDX_W-1:0]   in_dst;

	assign in_opc  = instruction_word[OPC_LSB +: FIELD_W];
	assign in_src  = idx_lut[instruction_word[SRC_LSB +: FIELD_W]];
	assign in_opnd = idx_lut[instruction_word[OPND_LSB +: FIELD_W]];
	assign in_dst  = idx_lut[instruction_word[0 +: FIELD_W]];

	// instruction held while it executes
	logic [FIELD_W-1:0] opc_q;
	logic [IDX_W-1:0]   opnd_q;
	logic [IDX_W-1:0]   dst_q;
	logic               imm_q;
	logic [IMM_W-1:0]   imm_val_q;
	logic [W-1:0]       a_q;
	logic               halted_q;

	// result waiting in S_RESP
	logic [W-1:0]       pend_val_q;
	logic               pend_we_q;
	status_t            pend_st_q;

	// output register
	logic               out_valid_q;
	logic [4:0]         dest_index_q;
	logic [OUT_W-1:0]   write_value_q;
	logic               write_enable_q;
	status_t            status_q;

	// register file: memory plus one valid bit per entry so reset reads as zero
	logic [REG_COUNT-1:0] vld_q;
	logic                 rd_vld_q;
	logic [IDX_W-1:0]     ram_raddr;
	logic [W-1:0]         ram_rdata;
	logic [W-1:0]         rf_data;
	logic                 ram_we;

	// alu interface
	alu_req_t             alu_req;
	alu_rsp_t             alu_rsp;
	logic [W-1:0]         alu_b;
	logic [W-1:0]         alu_res;

	logic                 in_fire;
	logic                 out_free;
	logic [EXT_W-1:0]     val_ext;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// operand a is read in the accept cycle, operand b in the cycle after
	assign ram_raddr = (state_q == S_IDLE) ? in_src : opnd_q;
	assign rf_data   = rd_vld_q ? ram_rdata : '0;
	assign ram_we    = (state_q == S_RESP) && out_free && pend_we_q;

	rae_ram #(
		.WIDTH (W),
		.DEPTH (REG_COUNT)
	) u_rf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (dst_q),
		.wdata (pend_val_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// immediate is zero-extended from 16 bits then cut to the data width
	assign alu_b         = imm_q ? W'(imm_val_q) : rf_data;
	assign alu_req.start = (state_q == S_LOAD);
	assign alu_req.op    = opcode_t'(opc_q);

	rae_alu #(
		.DATA_WIDTH (W)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (a_q),
		.b      (alu_b),
		.rsp    (alu_rsp),
		.res    (alu_res)
	);

	assign val_ext = EXT_W'(pend_val_q);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
			vld_q       <= '0;
			pend_we_q   <= 1'b0;
		end else begin
			// a new result replaces the one leaving in the same cycle
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						pend_we_q <= 1'b0;
						if (halted_q) begin
							state_q <= S_RESP;
						end else if (in_opc == OP_STOP) begin
							halted_q <= 1'b1;
							state_q  <= S_RESP;
						end else if (in_opc > OP_SEQ) begin
							state_q <= S_RESP;
						end else begin
							state_q <= S_RDB;
						end
					end
				end
				S_RDB: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (alu_rsp.done) begin
						pend_we_q <= 1'b1;
						state_q   <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						if (pend_we_q) begin
							vld_q[dst_q] <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		rd_vld_q <= vld_q[ram_raddr];
		if (in_fire) begin
			opc_q     <= in_opc;
			opnd_q    <= in_opnd;
			dst_q     <= in_dst;
			imm_q     <= instruction_word[IMM_BIT];
			imm_val_q <= instruction_word[OPND_LSB +: IMM_W];
			pend_val_q <= '0;
			if (halted_q) begin
				pend_st_q <= ST_HALTED;
			end else if (in_opc == OP_STOP) begin
				pend_st_q <= ST_STOP;
			end else if (in_opc > OP_SEQ) begin
				pend_st_q <= ST_UNSUP;
			end else begin
				pend_st_q <= ST_OK;
			end
		end
		if (state_q == S_RDB) begin
			a_q <= rf_data;
		end
		if (state_q == S_EXEC && alu_rsp.done) begin
			pend_val_q <= alu_res;
			pend_st_q  <= alu_rsp.div_zero ? ST_DIVZERO : ST_OK;
		end
		if (state_q == S_RESP && out_free) begin
			// no write reports zero index and value
			dest_index_q   <= pend_we_q ? 5'(dst_q) : '0;
			write_value_q  <= pend_we_q ? val_ext[OUT_W-1:0] : '0;
			write_enable_q <= pend_we_q;
			status_q       <= pend_st_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign dest_index   = dest_index_q;
	assign write_value  = write_value_q;
	assign write_enable = write_enable_q;
	assign status       = status_q;

endmodule
